// File: rtl/led_blink_mode_shift_driver_core_macros.svh
// Assertion macros used by the checker file of the LED blink shift driver.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef LED_BLINK_MODE_SHIFT_DRIVER_CORE_MACROS_SVH
`define LED_BLINK_MODE_SHIFT_DRIVER_CORE_MACROS_SVH

`define LBSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define LBSD_ASSERT_NEVER(label, expr, msg) \
    `LBSD_ASSERT(label, !(expr), msg)

`endif

// File: rtl/lbsd_pkg.sv
// Package for the LED blink shift driver: request kinds, mode codes and the
// per-channel LED level function. No dependencies.
package lbsd_pkg;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_SET_ONE = 2'd1;
    localparam logic [1:0] KIND_SET_ALL = 2'd2;

    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_ON     = 3'd1;
    localparam logic [2:0] MODE_FAST   = 3'd2;
    localparam logic [2:0] MODE_MEDIUM = 3'd3;
    localparam logic [2:0] MODE_SLOW   = 3'd4;

    localparam logic [15:0] PERIOD_RESET = 16'd150;

    typedef struct packed {
        logic       load;
        logic       shift;
        logic [2:0] phase;
        logic [2:0] mode;
    } cell_ctrl_t;

    function automatic logic led_level(input logic [2:0] mode, input logic [2:0] phase);
        logic level;
        case (mode)
            MODE_ON:     level = 1'b1;
            MODE_FAST:   level = phase[0];
            MODE_MEDIUM: level = phase[1];
            MODE_SLOW:   level = phase[2];
            default:     level = 1'b0;
        endcase
        return level;
    endfunction

endpackage

// File: rtl/lbsd_cell.sv
// One channel cell of the LED blink shift driver: holds the channel mode and
// one stage of the serial frame chain. Depends on lbsd_pkg.
module lbsd_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lbsd_pkg::cell_ctrl_t  ctrl,
    input  logic                  set_en,
    input  logic                  shift_in,
    output logic                  shift_out
);

    logic [2:0] mode_reg;
    logic       bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= lbsd_pkg::MODE_OFF;
        end else if (set_en) begin
            mode_reg <= ctrl.mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            bit_reg <= lbsd_pkg::led_level(mode_reg, ctrl.phase);
        end else if (ctrl.shift) begin
            bit_reg <= shift_in;
        end
    end

    assign shift_out = bit_reg;

endmodule

// File: rtl/led_blink_mode_shift_driver_core.sv
// LED blink shift driver top level: request decode, tick and phase timing,
// and the chain of channel cells. Depends on lbsd_pkg and lbsd_cell.
//
// A tick request loads the LED level of every channel into a chain of
// CHANNELS cells, which then shifts one bit per accepted result, highest
// channel first, with latch set on channel 0. A tick therefore occupies the
// result channel for CHANNELS results; the next tick is taken in the same
// cycle as the last bit of the current frame leaves. Mode set requests are
// taken every cycle, also while a frame is shifting, and show in the next
// frame.
module led_blink_mode_shift_driver_core #(
    parameter int CHANNELS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [3:0]  s_channel,
    input  logic [2:0]  s_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_data_bit,
    output logic [3:0]  m_bit_channel,
    output logic        m_latch
);

    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int IDX_W = $clog2(CHANNELS);

    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [15:0]      period_reg;
    logic [15:0]      tick_reg, tick_next;
    logic [2:0]       phase_reg, phase_next;
    logic [15:0]      tick_inc;
    logic             frame_free;
    logic             accept;
    logic             is_tick;
    logic             shift;
    logic [IDX_W-1:0] out_idx;
    logic [CHANNELS-1:0] set_en;
    logic [CHANNELS:0]   chain;
    lbsd_pkg::cell_ctrl_t ctrl;

    assign frame_free = (bit_cnt_reg == '0) || (m_latch && m_ready);
    assign s_ready    = frame_free || (s_kind != lbsd_pkg::KIND_TICK);
    assign accept     = s_valid && s_ready;
    assign is_tick    = accept && (s_kind == lbsd_pkg::KIND_TICK);
    assign shift      = m_valid && m_ready;

    always_comb begin
        tick_inc   = tick_reg + 16'd1;
        tick_next  = tick_reg;
        phase_next = phase_reg;
        if (is_tick) begin
            if (tick_inc >= period_reg) begin
                tick_next  = '0;
                phase_next = phase_reg + 3'd1;
            end else begin
                tick_next = tick_inc;
            end
        end
    end

    always_comb begin
        bit_cnt_next = bit_cnt_reg;
        if (is_tick) begin
            bit_cnt_next = CNT_W'(CHANNELS);
        end else if (shift) begin
            bit_cnt_next = bit_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            period_reg  <= lbsd_pkg::PERIOD_RESET;
            tick_reg    <= '0;
            phase_reg   <= '0;
        end else begin
            bit_cnt_reg <= bit_cnt_next;
            tick_reg    <= tick_next;
            phase_reg   <= phase_next;
            if (cfg_we) begin
                period_reg <= cfg_wdata;
            end
        end
    end

    assign ctrl.load  = is_tick;
    assign ctrl.shift = shift;
    assign ctrl.phase = phase_next;
    assign ctrl.mode  = s_mode;

    assign chain[0] = 1'b0;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        assign set_en[i] = accept && ((s_kind == lbsd_pkg::KIND_SET_ALL) ||
                           ((s_kind == lbsd_pkg::KIND_SET_ONE) && (int'(s_channel) == i)));

        lbsd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .set_en    (set_en[i]),
            .shift_in  (chain[i]),
            .shift_out (chain[i+1])
        );
    end

    assign out_idx       = IDX_W'(bit_cnt_reg - CNT_W'(1));
    assign m_valid       = (bit_cnt_reg != '0);
    assign m_data_bit    = chain[CHANNELS];
    assign m_bit_channel = 4'(out_idx);
    assign m_latch       = (bit_cnt_reg == CNT_W'(1));

endmodule

// File: rtl/lbsd_port_checker.sv
// Port-level checker for the LED blink shift driver, bound to the top level.
// Depends on lbsd_pkg and led_blink_mode_shift_driver_core_macros.svh.
`include "led_blink_mode_shift_driver_core_macros.svh"

module lbsd_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_kind,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_data_bit,
    input logic [3:0]  m_bit_channel,
    input logic        m_latch
);

    `LBSD_ASSERT(a_out_hold,
        m_valid && !m_ready |=> m_valid && $stable(m_data_bit) &&
        $stable(m_bit_channel) && $stable(m_latch),
        "result changed while stalled")
    `LBSD_ASSERT_NEVER(a_latch_chan, m_valid && m_latch && (m_bit_channel != 4'd0),
        "latch not on channel 0")
    `LBSD_ASSERT(a_chan_step,
        m_valid && m_ready && !m_latch |=>
        m_valid && (m_bit_channel == $past(m_bit_channel) - 4'd1),
        "frame channel order broken")
    `LBSD_ASSERT(a_tick_gap,
        s_valid && s_ready && (s_kind == lbsd_pkg::KIND_TICK) && m_valid |->
        m_ready && m_latch,
        "tick request taken inside a frame")

endmodule

bind led_blink_mode_shift_driver_core lbsd_port_checker u_lbsd_port_checker (.*);
